// ===== rtl/core/lsod_pkg.sv =====
`timescale 1ns / 1ps
package lsod_pkg;

  // Screen size defaults.
  localparam int SCREEN_WIDTH_DEF  = 256;
  localparam int SCREEN_HEIGHT_DEF = 256;

  // Configuration register indexes.
  localparam logic CFG_LIGHT_X = 1'b0;
  localparam logic CFG_LIGHT_Z = 1'b1;

  localparam logic signed [15:0] LIGHT_X_RESET = 16'sd16384;
  localparam logic signed [15:0] LIGHT_Z_RESET = 16'sd0;

  // 1.0 and the inner radius squared (0.9801) in Q4.28.
  localparam logic [31:0] ONE_Q28  = 32'd268435456;
  localparam logic [31:0] RING_Q28 = 32'd263093590;
  localparam int Q14_MAX = 32767;

  // Number of bits in the square root and the remainder it works on.
  localparam int ROOT_W = 15;
  localparam int REM_W  = 29;

  // 8x8 Bayer matrix, indexed by {row[2:0], column[2:0]}.
  localparam logic [5:0] BAYER [64] = '{
    6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
    6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
    6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
    6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
    6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
    6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
    6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
    6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
  };

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_x;
    logic [7:0] out_y;
    logic       ink;
  } result_t;

  // Side data that travels with a pixel down the root chain.
  typedef struct packed {
    logic [7:0]         px;
    logic [7:0]         py;
    logic [5:0]         thr_idx;
    logic               in_disc;
    logic               ring;
    logic signed [31:0] ux;
  } tag_t;

endpackage

// ===== rtl/core/lsod_stream_if.sv =====
`timescale 1ns / 1ps
interface lsod_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/lit_sphere_ordered_dither.sv =====
`timescale 1ns / 1ps
// Lit-sphere ordered dither.
// Each transaction on the pix channel carries one pixel coordinate; the res
// channel returns one transaction per pixel, in order, with the coordinate
// and an ink bit (1 draws black). The sphere is shaded by a Lambert term from
// the light direction in light_x and light_z and dithered with an 8x8 Bayer
// matrix; a thin ring at the rim is always inked and pixels outside stay white.
// The registers are written through cfg_we, cfg_addr and cfg_data and should
// only change while no pixel is in flight.
// Throughput is one pixel per clock while the receiver takes results. A
// pixel passes three front stages (lookup, squares, radius test), a chain
// of 15 cells that each settle one bit of the square root, and two shading
// stages, the last of which is the output register.
// Every stage has its own valid bit and loads whenever its successor has
// room, so bubbles close up and new pixels are taken while a result waits.
// When the receiver stalls, the chain fills and pix ready drops once every
// stage is holding a pixel. Reset clears all valid bits and loads the
// default light direction; no pixel is lost to a stall.
module lit_sphere_ordered_dither import lsod_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  lsod_stream_if.sink         pix,
  lsod_stream_if.source       res,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic signed [15:0]  cfg_data
);

  logic signed [15:0] light_x;
  logic signed [15:0] light_z;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= LIGHT_X_RESET;
      light_z <= LIGHT_Z_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LIGHT_X: light_x <= cfg_data;
        CFG_LIGHT_Z: light_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Links of the root chain; link 0 is the front end output.
  logic              link_valid [ROOT_W+1];
  logic              link_ready [ROOT_W+1];
  tag_t              link_tag   [ROOT_W+1];
  logic [REM_W-1:0]  link_rem   [ROOT_W+1];
  logic [ROOT_W-1:0] link_root  [ROOT_W+1];

  pixel_t pix_data;
  assign pix_data = pix.data;

  lsod_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pix.valid),
    .up_ready (pix.ready),
    .up_data  (pix_data),
    .light_x  (light_x),
    .dn_valid (link_valid[0]),
    .dn_ready (link_ready[0]),
    .dn_tag   (link_tag[0]),
    .dn_rem   (link_rem[0])
  );

  assign link_root[0] = '0;

  // The most significant root bit is settled first.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    lsod_root_cell #(
      .STEP (ROOT_W - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (link_valid[k]),
      .up_ready (link_ready[k]),
      .up_tag   (link_tag[k]),
      .up_rem   (link_rem[k]),
      .up_root  (link_root[k]),
      .dn_valid (link_valid[k+1]),
      .dn_ready (link_ready[k+1]),
      .dn_tag   (link_tag[k+1]),
      .dn_rem   (link_rem[k+1]),
      .dn_root  (link_root[k+1])
    );
  end

  result_t res_data;
  assign res.data = res_data;

  lsod_shade u_shade (
    .clk      (clk),
    .rst      (rst),
    .up_valid (link_valid[ROOT_W]),
    .up_ready (link_ready[ROOT_W]),
    .up_tag   (link_tag[ROOT_W]),
    .up_root  (link_root[ROOT_W]),
    .light_z  (light_z),
    .dn_valid (res.valid),
    .dn_ready (res.ready),
    .dn_data  (res_data)
  );

endmodule

// ===== rtl/core/lsod_front.sv =====
`timescale 1ns / 1ps
module lsod_front import lsod_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  pixel_t                up_data,
  input  logic signed [15:0]    light_x,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output tag_t                  dn_tag,
  output logic [REM_W-1:0]      dn_rem
);

  // Coordinate to Q2.14 lookup, rounded half away from zero and saturated.
  logic signed [15:0] u_tab [256];
  logic signed [15:0] v_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_tab
    localparam int UNUM = 2 * g + 1 - SCREEN_WIDTH;
    localparam int UMAG = (UNUM < 0) ? -UNUM : UNUM;
    localparam int UQ0  = (2 * UMAG * 16384 + SCREEN_WIDTH) / (2 * SCREEN_WIDTH);
    localparam int UQ   = (UQ0 > Q14_MAX) ? Q14_MAX : UQ0;
    localparam int VNUM = SCREEN_HEIGHT - 2 * g - 1;
    localparam int VMAG = (VNUM < 0) ? -VNUM : VNUM;
    localparam int VQ0  = (2 * VMAG * 16384 + SCREEN_HEIGHT) / (2 * SCREEN_HEIGHT);
    localparam int VQ   = (VQ0 > Q14_MAX) ? Q14_MAX : VQ0;
    assign u_tab[g] = 16'((UNUM < 0) ? -UQ : UQ);
    assign v_tab[g] = 16'((VNUM < 0) ? -VQ : VQ);
  end

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // Stage 1: mapped coordinates.
  logic signed [15:0] u1, s1;
  logic [7:0]         px1, py1;

  // Stage 2: squares and the light x product.
  logic [29:0]        uu2, vv2;
  logic signed [31:0] ux2;
  logic [7:0]         px2, py2;

  logic signed [31:0] uu_full, vv_full, ux_full;
  logic [31:0]        d2;

  assign rdy3     = !v3 || dn_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v3;

  assign uu_full = u1 * u1;
  assign vv_full = s1 * s1;
  assign ux_full = u1 * light_x;
  assign d2      = 32'(uu2) + 32'(vv2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      u1  <= u_tab[up_data.pixel_x];
      s1  <= v_tab[up_data.pixel_y];
      px1 <= up_data.pixel_x;
      py1 <= up_data.pixel_y;
    end
    if (rdy2 && v1) begin
      uu2 <= uu_full[29:0];
      vv2 <= vv_full[29:0];
      ux2 <= ux_full;
      px2 <= px1;
      py2 <= py1;
    end
    if (rdy3 && v2) begin
      dn_tag.px      <= px2;
      dn_tag.py      <= py2;
      dn_tag.thr_idx <= BAYER[{py2[2:0], px2[2:0]}];
      dn_tag.in_disc <= (d2 < RING_Q28);
      dn_tag.ring    <= (d2 < ONE_Q28);
      dn_tag.ux      <= ux2;
      dn_rem         <= (d2 < RING_Q28) ? REM_W'(ONE_Q28 - d2) : '0;
    end
  end

endmodule

// ===== rtl/core/lsod_root_cell.sv =====
`timescale 1ns / 1ps
module lsod_root_cell import lsod_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  tag_t              up_tag,
  input  logic [REM_W-1:0]  up_rem,
  input  logic [ROOT_W-1:0] up_root,
  output logic              dn_valid,
  input  logic              dn_ready,
  output tag_t              dn_tag,
  output logic [REM_W-1:0]  dn_rem,
  output logic [ROOT_W-1:0] dn_root
);

  // One digit of a restoring square root: (r + 2^s)^2 - r^2 = r*2^(s+1) + 2^(2s).
  logic [30:0] trial;
  logic        take;

  assign trial    = (31'(up_root) << (STEP + 1)) | (31'(1) << (2 * STEP));
  assign take     = {2'b00, up_rem} >= trial;
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_tag  <= up_tag;
      dn_rem  <= take ? (up_rem - trial[REM_W-1:0]) : up_rem;
      dn_root <= take ? (up_root | (ROOT_W'(1) << STEP)) : up_root;
    end
  end

endmodule

// ===== rtl/core/lsod_shade.sv =====
`timescale 1ns / 1ps
module lsod_shade import lsod_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  tag_t               up_tag,
  input  logic [ROOT_W-1:0]  up_root,
  input  logic signed [15:0] light_z,
  output logic               dn_valid,
  input  logic               dn_ready,
  output result_t            dn_data
);

  logic v1, rdy1, rdy2;

  logic signed [31:0] zl;
  logic signed [32:0] term;
  logic [REM_W-1:0]   black_next;

  logic [REM_W-1:0] black;
  logic [7:0]       px1, py1;
  logic [5:0]       tidx1;
  logic             inside1, ring1;
  logic [REM_W-1:0] thr;

  assign zl   = $signed({1'b0, up_root}) * light_z;
  assign term = 33'(up_tag.ux) + 33'(zl);

  // Clamp the Lambert term to [0, 1] and take blackness = 1 - term.
  always_comb begin
    if (term < 0) begin
      black_next = REM_W'(ONE_Q28);
    end else if (term > $signed({1'b0, ONE_Q28})) begin
      black_next = '0;
    end else begin
      black_next = REM_W'(ONE_Q28 - 32'(term));
    end
  end

  // Threshold (2t + 1) * 2^21.
  assign thr = {1'b0, tidx1, 1'b1, 21'd0};

  assign rdy2     = !dn_valid || dn_ready;
  assign rdy1     = !v1 || rdy2;
  assign up_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) dn_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      black   <= black_next;
      px1     <= up_tag.px;
      py1     <= up_tag.py;
      tidx1   <= up_tag.thr_idx;
      inside1 <= up_tag.in_disc;
      ring1   <= up_tag.ring;
    end
    if (rdy2 && v1) begin
      dn_data.out_x <= px1;
      dn_data.out_y <= py1;
      dn_data.ink   <= inside1 ? (black > thr) : ring1;
    end
  end

endmodule

// ===== tb/sv/lit_sphere_ordered_dither_tb.sv =====
`timescale 1ns / 1ps
module lit_sphere_ordered_dither_tb;
  import lsod_pkg::*;

  // The block is built with its default screen size.
  localparam longint SCREEN_W = 256;
  localparam longint SCREEN_H = 256;

  // Fixed-point landmarks in Q4.28: the unit radius squared and the inner
  // radius squared (0.99 squared), below which the sphere is shaded.
  localparam longint UNIT_Q28      = 64'sd268435456;
  localparam longint DISC_EDGE_Q28 = 64'sd263093590;
  localparam longint Q14_LIMIT     = 64'sd32767;
  // Half a Bayer step (1/128) in Q4.28; thresholds are odd multiples of it.
  localparam longint HALF_RANK_Q28 = 64'sd2097152;

  // Ordered dither ranks, row-major by pixel row, then column.
  localparam logic [5:0] DITHER_RANK [64] = '{
    6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
    6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
    6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
    6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
    6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
    6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
    6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
    6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
  };

  // The pipeline is 20 stages deep; this wait covers anything still in flight.
  localparam int SETTLE_CYCLES  = 24;
  // A run with nothing accepted for this many cycles is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 94;
  localparam int PHASES          = 8;

  // Shading predictor and in-order store of the ink results still owed.
  class ink_scoreboard;
    longint  light_x;
    longint  light_z;
    result_t awaiting[$];
    int      failures;

    function new();
      light_x  = 16384;
      light_z  = 0;
      failures = 0;
    endfunction

    // Registers are 16-bit two's complement and taken as written.
    function void set_light(logic addr, logic [15:0] val);
      if (addr == CFG_LIGHT_X) begin
        light_x = longint'($signed(val));
      end else begin
        light_z = longint'($signed(val));
      end
    endfunction

    // Rounds num / den into Q2.14, ties away from zero, with saturation.
    function longint to_q14(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag * 16384 + den) / (2 * den);
      if (q > Q14_LIMIT) q = Q14_LIMIT;
      return (num < 0) ? -q : q;
    endfunction

    // Bit-serial floor root with exactly 15 result bits.
    function longint root15(longint n);
      longint r;
      longint trial;
      r = 0;
      for (int i = 14; i >= 0; i--) begin
        trial = r | (longint'(1) << i);
        if (trial * trial <= n) r = trial;
      end
      return r;
    endfunction

    function logic shade(logic [7:0] px, logic [7:0] py);
      longint u;
      longint v;
      longint d2;
      longint z;
      longint term;
      longint thr;
      u = to_q14(2 * longint'(px) + 1 - SCREEN_W, SCREEN_W);
      v = to_q14(SCREEN_H - 2 * longint'(py) - 1, SCREEN_H);
      d2 = u * u + v * v;
      if (d2 >= UNIT_Q28) return 1'b0;
      if (d2 >= DISC_EDGE_Q28) return 1'b1;
      z = root15(UNIT_Q28 - d2);
      term = u * light_x + z * light_z;
      if (term < 0) term = 0;
      if (term > UNIT_Q28) term = UNIT_Q28;
      thr = (2 * longint'(DITHER_RANK[{py[2:0], px[2:0]}]) + 1) * HALF_RANK_Q28;
      return ((UNIT_Q28 - term) > thr) ? 1'b1 : 1'b0;
    endfunction

    function void note_pixel(logic [7:0] px, logic [7:0] py);
      result_t want;
      want.out_x = px;
      want.out_y = py;
      want.ink   = shade(px, py);
      awaiting.push_back(want);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaiting.size() == 0) begin
        note_failure($sformatf("unexpected result (%0d,%0d) ink %0b",
                               got.out_x, got.out_y, got.ink));
        return;
      end
      want = awaiting.pop_front();
      if (got.out_x !== want.out_x || got.out_y !== want.out_y || got.ink !== want.ink) begin
        note_failure($sformatf("expected (%0d,%0d) ink %0b, got (%0d,%0d) ink %0b",
                               want.out_x, want.out_y, want.ink,
                               got.out_x, got.out_y, got.ink));
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic               cfg_addr;
  logic signed [15:0] cfg_data;

  // When clear, both the pixel source and the result sink run flat out.
  bit idle_on;
  int quiet_cycles;

  ink_scoreboard ink_sb = new();

  lsod_stream_if #(.payload_t(pixel_t))  pix_ch ();
  lsod_stream_if #(.payload_t(result_t)) res_ch ();

  lit_sphere_ordered_dither DUT (
    .clk      (clk),
    .rst      (rst),
    .pix      (pix_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Idle lengths for either side of the block. Most gaps are zero or short,
  // and an occasional long one lets the pipeline fill or drain.
  function automatic int draw_gap();
    int pick;
    if (!idle_on) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one pixel and holds it until the block takes it. The expected
  // result is computed at acceptance, with the light direction in force.
  // Valid stays high into the next call when no gap is drawn.
  task automatic send_pixel(input logic [7:0] px, input logic [7:0] py);
    int gap;
    pix_ch.valid <= 1'b1;
    pix_ch.data  <= '{pixel_x: px, pixel_y: py};
    do @(posedge clk); while (!pix_ch.ready);
    ink_sb.note_pixel(px, py);
    gap = draw_gap();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering pixels and waits for every owed result, then lets the
  // pipeline go quiet. The watchdog bounds the wait.
  task automatic settle();
    pix_ch.valid <= 1'b0;
    while (ink_sb.awaiting.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. The enable is lowered before the task returns, so
  // back-to-back writes never toggle it within one step.
  task automatic write_light(input logic addr, input logic signed [15:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    ink_sb.set_light(addr, val);
    @(posedge clk);
  endtask

  // Mixes scattered pixels with short runs along one row, the way a raster
  // scan would feed the block, so neighboring dither cells follow each other.
  task automatic random_phase(input int count);
    int         sent;
    int         run;
    logic [7:0] px;
    logic [7:0] py;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 3) == 0) begin
        px  = 8'($urandom);
        py  = 8'($urandom);
        run = $urandom_range(2, 16);
        while (run > 0 && sent < count) begin
          send_pixel(px, py);
          px++;
          run--;
          sent++;
        end
      end else begin
        send_pixel(8'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  // Result sink: ready is held for a random run, then dropped for a gap.
  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      gap = draw_gap();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Every accepted result transaction is checked against the oldest
  // expectation. Values are read before this edge's updates take effect.
  always @(posedge clk) begin
    if (rst === 1'b0 && res_ch.valid && res_ch.ready) begin
      ink_sb.check_result(res_ch.data);
    end
  end

  // The watchdog restarts whenever a transaction moves on either channel.
  always @(posedge clk) begin
    if (rst !== 1'b0 || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic signed [15:0] lx;
    logic signed [15:0] lz;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_addr     <= CFG_LIGHT_X;
    cfg_data     <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.data  <= '0;
    idle_on = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed pixels under the reset light, which comes from the right.
    // Screen corners lie outside the disc and stay white.
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd255, 8'd0);
    // The screen center, where u and v are plus or minus half a pixel.
    send_pixel(8'd127, 8'd127);
    send_pixel(8'd128, 8'd128);
    // Pixels on the rim ring at the right, left, top and bottom edges.
    send_pixel(8'd255, 8'd127);
    send_pixel(8'd0, 8'd128);
    send_pixel(8'd127, 8'd0);
    send_pixel(8'd128, 8'd255);
    // Their neighbors just inside the inner radius, which are shaded.
    send_pixel(8'd254, 8'd127);
    send_pixel(8'd127, 8'd1);
    send_pixel(8'd1, 8'd128);
    send_pixel(8'd128, 8'd254);
    // The lit and the dark side, and dither cells of rank 0 and of higher ranks.
    send_pixel(8'd200, 8'd100);
    send_pixel(8'd60, 8'd140);
    send_pixel(8'd64, 8'd64);
    send_pixel(8'd135, 8'd135);
    send_pixel(8'd170, 8'd85);
    send_pixel(8'd85, 8'd170);
    settle();

    // Each phase sets a new light direction while the block is idle. The
    // first phases cover the axis directions and the diagonal; later ones
    // push the registers beyond unit length to the 16-bit extremes, and the
    // last two use random directions. Every third phase runs without gaps.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          lx = 16'sd0;
          lz = 16'sd16384;
        end
        1: begin
          lx = -16'sd16384;
          lz = 16'sd0;
        end
        2: begin
          lx = 16'sd11585;
          lz = 16'sd11585;
        end
        3: begin
          lx = 16'sd16384;
          lz = -16'sd16384;
        end
        4: begin
          lx = 16'sd32767;
          lz = -16'sd32768;
        end
        5: begin
          lx = -16'sd32768;
          lz = 16'sd32767;
        end
        6: begin
          lx = 16'($signed($urandom_range(0, 32768)) - 16384);
          lz = 16'($signed($urandom_range(0, 32768)) - 16384);
        end
        default: begin
          lx = 16'($urandom);
          lz = 16'($urandom);
        end
      endcase
      write_light(CFG_LIGHT_X, lx);
      write_light(CFG_LIGHT_Z, lz);
      idle_on = (phase % 3 != 2);
      random_phase(ITEMS_PER_PHASE);
      settle();
    end

    if (ink_sb.failures == 0 && ink_sb.awaiting.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
